// ----- rtl/cdu_pkg.sv -----
// ----------------------------------------------------------------------------
// cdu_pkg
// Types, widths and tables shared by the calendar time difference pipeline.
// ----------------------------------------------------------------------------
package cdu_pkg;

  // input field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // result field widths
  localparam int DIFF_W = 40;
  localparam int UNIT_W = 4;

  // internal year, wide enough for any year ceiling
  localparam int Y_W = 16;
  localparam logic [Y_W-1:0] MAX_YEAR = 16'd9999;

  // century count ceil(y/100) = floor((y+99)/100) by reciprocal multiply
  localparam int X_W = Y_W + 1;
  localparam logic [X_W-1:0] CENT_BIAS = 17'd99;
  localparam logic [X_W-1:0] DIV100_K  = 17'd83887;
  localparam int DIV100_SH = 23;
  localparam int P_W = 2 * X_W;
  localparam int Q_W = P_W - DIV100_SH;

  // small divide by three of an hour offset
  localparam int QP_W = HOUR_W + 4;
  localparam logic [QP_W-1:0] DIV3_K = 9'd11;
  localparam int DIV3_SH = 5;
  localparam int Q3_W = QP_W - DIV3_SH;

  localparam int DOY_W = 9;
  localparam logic [DOY_W-1:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  localparam int DN_W   = 25;
  localparam int DAYS_W = DN_W + 1;
  localparam int HR_W   = 31;
  localparam int MN_W   = 37;
  localparam int SC_W   = 42;

  localparam int YD_W  = Y_W + 1;
  localparam int MD_W  = 21;
  localparam int DM_W  = MONTH_W + 1;
  localparam int DH_W  = HOUR_W + 1;
  localparam int DMI_W = MINUTE_W + 1;
  localparam int DS_W  = SECOND_W + 1;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_YEAR   = 4'd0,
    UNIT_MONTH  = 4'd1,
    UNIT_DAY    = 4'd2,
    UNIT_12H    = 4'd3,
    UNIT_6H     = 4'd4,
    UNIT_3H     = 4'd5,
    UNIT_HOUR   = 4'd6,
    UNIT_MINUTE = 4'd7,
    UNIT_SECOND = 4'd8
  } unit_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } stamp_t;

  // comparisons and field differences that ride along to the final select
  typedef struct packed {
    logic                    eq_m;
    logic                    eq_d;
    logic                    eq_h;
    logic                    eq_n;
    logic                    eq_s;
    logic signed [YD_W-1:0]  ydiff;
    logic signed [MD_W-1:0]  mdiff;
    logic signed [DH_W-1:0]  dh;
    logic signed [DMI_W-1:0] dmi;
    logic signed [DS_W-1:0]  ds;
  } ctx_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [Y_W-1:0]    ya;
    logic [Y_W-1:0]    yb;
    logic [P_W-1:0]    pa;
    logic [P_W-1:0]    pb;
    logic [DN_W-1:0]   y365a;
    logic [DN_W-1:0]   y365b;
    logic [DOY_W-1:0]  doya;
    logic [DOY_W-1:0]  doyb;
    logic              late_a;
    logic              late_b;
  } prep_t;

  typedef struct packed {
    ctx_t                     ctx;
    logic signed [DAYS_W-1:0] days;
  } days_t;

  // days before the first of the month, month saturated to 1..12
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] d;
    unique case (month) inside
      4'd0, 4'd1:          d = 9'd0;
      4'd2:                d = 9'd31;
      4'd3:                d = 9'd59;
      4'd4:                d = 9'd90;
      4'd5:                d = 9'd120;
      4'd6:                d = 9'd151;
      4'd7:                d = 9'd181;
      4'd8:                d = 9'd212;
      4'd9:                d = 9'd243;
      4'd10:               d = 9'd273;
      4'd11:               d = 9'd304;
      4'd12, [4'd13:4'd15]: d = 9'd334;
      default:             d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/cdu_prep.sv -----
// ----------------------------------------------------------------------------
// cdu_prep
// First stage: saturate years, compare fields, start the day-number sums.
// ----------------------------------------------------------------------------
module cdu_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  cdu_pkg::stamp_t  stamp_a,
  input  cdu_pkg::stamp_t  stamp_b,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cdu_pkg::prep_t   dn_data
);

  logic [cdu_pkg::Y_W-1:0]            ya;
  logic [cdu_pkg::Y_W-1:0]            yb;
  logic [cdu_pkg::X_W-1:0]            xa;
  logic [cdu_pkg::X_W-1:0]            xb;
  logic signed [cdu_pkg::DM_W-1:0]    dm;
  cdu_pkg::prep_t                     prep_nxt;
  cdu_pkg::prep_t                     prep_r;
  logic                               v_r;

  assign ya = ({2'b00, stamp_a.year} > cdu_pkg::MAX_YEAR) ? cdu_pkg::MAX_YEAR
                                                          : cdu_pkg::Y_W'(stamp_a.year);
  assign yb = ({2'b00, stamp_b.year} > cdu_pkg::MAX_YEAR) ? cdu_pkg::MAX_YEAR
                                                          : cdu_pkg::Y_W'(stamp_b.year);
  assign xa = cdu_pkg::X_W'(ya) + cdu_pkg::CENT_BIAS;
  assign xb = cdu_pkg::X_W'(yb) + cdu_pkg::CENT_BIAS;
  assign dm = $signed({1'b0, stamp_a.month}) - $signed({1'b0, stamp_b.month});

  always_comb begin
    prep_nxt.ctx.eq_m  = (stamp_a.month == stamp_b.month);
    prep_nxt.ctx.eq_d  = (stamp_a.day == stamp_b.day);
    prep_nxt.ctx.eq_h  = (stamp_a.hour == stamp_b.hour);
    prep_nxt.ctx.eq_n  = (stamp_a.minute == stamp_b.minute);
    prep_nxt.ctx.eq_s  = (stamp_a.second == stamp_b.second);
    prep_nxt.ctx.ydiff = $signed({1'b0, ya}) - $signed({1'b0, yb});
    prep_nxt.ctx.mdiff = (cdu_pkg::MD_W'(prep_nxt.ctx.ydiff) <<< 3)
                       + (cdu_pkg::MD_W'(prep_nxt.ctx.ydiff) <<< 2)
                       + cdu_pkg::MD_W'(dm);
    prep_nxt.ctx.dh    = $signed({1'b0, stamp_a.hour}) - $signed({1'b0, stamp_b.hour});
    prep_nxt.ctx.dmi   = $signed({1'b0, stamp_a.minute}) - $signed({1'b0, stamp_b.minute});
    prep_nxt.ctx.ds    = $signed({1'b0, stamp_a.second}) - $signed({1'b0, stamp_b.second});
    prep_nxt.ya        = ya;
    prep_nxt.yb        = yb;
    prep_nxt.pa        = cdu_pkg::P_W'(xa) * cdu_pkg::P_W'(cdu_pkg::DIV100_K);
    prep_nxt.pb        = cdu_pkg::P_W'(xb) * cdu_pkg::P_W'(cdu_pkg::DIV100_K);
    prep_nxt.y365a     = cdu_pkg::DN_W'(ya) * cdu_pkg::DN_W'(cdu_pkg::DAYS_PER_YEAR);
    prep_nxt.y365b     = cdu_pkg::DN_W'(yb) * cdu_pkg::DN_W'(cdu_pkg::DAYS_PER_YEAR);
    prep_nxt.doya      = cdu_pkg::days_before(stamp_a.month)
                       + cdu_pkg::DOY_W'(stamp_a.day);
    prep_nxt.doyb      = cdu_pkg::days_before(stamp_b.month)
                       + cdu_pkg::DOY_W'(stamp_b.day);
    prep_nxt.late_a    = (stamp_a.month > cdu_pkg::MONTH_FEB);
    prep_nxt.late_b    = (stamp_b.month > cdu_pkg::MONTH_FEB);
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      prep_r <= prep_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = prep_r;

endmodule

// ----- rtl/cdu_daynum.sv -----
// ----------------------------------------------------------------------------
// cdu_daynum
// Two stages: finish leap counts and day numbers, then take the day difference.
// ----------------------------------------------------------------------------
module cdu_daynum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cdu_pkg::prep_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cdu_pkg::days_t  dn_data
);

  // day number without the leap-day correction for March onwards
  function automatic logic [cdu_pkg::DN_W-1:0] base_of(
    input logic [cdu_pkg::Y_W-1:0]   y,
    input logic [cdu_pkg::P_W-1:0]   p,
    input logic [cdu_pkg::DN_W-1:0]  y365,
    input logic [cdu_pkg::DOY_W-1:0] doy
  );
    logic [cdu_pkg::DN_W-1:0] q;
    logic [cdu_pkg::DN_W-1:0] leaps;
    q     = cdu_pkg::DN_W'(p[cdu_pkg::P_W-1:cdu_pkg::DIV100_SH]);
    leaps = ((cdu_pkg::DN_W'(y) + cdu_pkg::DN_W'(3)) >> 2) - q
          + ((q + cdu_pkg::DN_W'(3)) >> 2);
    return y365 + leaps + cdu_pkg::DN_W'(doy);
  endfunction

  // q is ceil(y/100), so y is a whole century exactly when q*100 == y
  function automatic logic leap_of(
    input logic [cdu_pkg::Y_W-1:0] y,
    input logic [cdu_pkg::P_W-1:0] p
  );
    logic [cdu_pkg::Q_W-1:0] q;
    logic                    cent;
    q    = p[cdu_pkg::P_W-1:cdu_pkg::DIV100_SH];
    cent = (cdu_pkg::DN_W'(q) * cdu_pkg::DN_W'(100) == cdu_pkg::DN_W'(y));
    return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
  endfunction

  logic                        v2_r;
  logic                        v3_r;
  logic                        rdy2;
  logic                        rdy3;
  cdu_pkg::ctx_t               ctx2_r;
  logic [cdu_pkg::DN_W-1:0]    basea_r;
  logic [cdu_pkg::DN_W-1:0]    baseb_r;
  logic                        adja_r;
  logic                        adjb_r;
  logic [cdu_pkg::DN_W-1:0]    basea_nxt;
  logic [cdu_pkg::DN_W-1:0]    baseb_nxt;
  logic                        adja_nxt;
  logic                        adjb_nxt;
  logic [cdu_pkg::DN_W-1:0]    dna;
  logic [cdu_pkg::DN_W-1:0]    dnb;
  cdu_pkg::days_t              days_nxt;
  cdu_pkg::days_t              days_r;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign up_ready = rdy2;

  assign basea_nxt = base_of(up_data.ya, up_data.pa, up_data.y365a, up_data.doya);
  assign baseb_nxt = base_of(up_data.yb, up_data.pb, up_data.y365b, up_data.doyb);
  assign adja_nxt  = leap_of(up_data.ya, up_data.pa) && up_data.late_a;
  assign adjb_nxt  = leap_of(up_data.yb, up_data.pb) && up_data.late_b;

  assign dna = basea_r + cdu_pkg::DN_W'(adja_r);
  assign dnb = baseb_r + cdu_pkg::DN_W'(adjb_r);

  always_comb begin
    days_nxt.ctx  = ctx2_r;
    days_nxt.days = $signed({1'b0, dna}) - $signed({1'b0, dnb});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= up_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ctx2_r  <= up_data.ctx;
      basea_r <= basea_nxt;
      baseb_r <= baseb_nxt;
      adja_r  <= adja_nxt;
      adjb_r  <= adjb_nxt;
    end
    if (rdy3) begin
      days_r <= days_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = days_r;

endmodule

// ----- rtl/cdu_scale.sv -----
// ----------------------------------------------------------------------------
// cdu_scale
// Three stages: hours and hour units, minutes, then seconds and unit select.
// ----------------------------------------------------------------------------
module cdu_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  cdu_pkg::days_t                   up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [cdu_pkg::DIFF_W-1:0] dn_diff,
  output cdu_pkg::unit_t                   dn_unit
);

  logic v4_r;
  logic v5_r;
  logic v6_r;
  logic rdy4;
  logic rdy5;
  logic rdy6;

  // stage 4
  logic signed [cdu_pkg::DAYS_W-1:0] days4;
  logic signed [cdu_pkg::DH_W-1:0]   dh4;
  logic                              neg4;
  logic [cdu_pkg::HOUR_W-1:0]        adh;
  logic [cdu_pkg::QP_W-1:0]          q3p;
  logic [cdu_pkg::Q3_W-1:0]          q3;
  logic                              d3;
  logic                              d6;
  logic                              d12;
  logic [cdu_pkg::Q3_W-1:0]          qsel;
  logic signed [cdu_pkg::HR_W-1:0]   hbase;
  logic signed [cdu_pkg::HR_W-1:0]   qx;
  logic signed [cdu_pkg::HR_W-1:0]   hours_nxt;
  logic signed [cdu_pkg::HR_W-1:0]   hcand_nxt;
  cdu_pkg::unit_t                    hunit_nxt;

  cdu_pkg::ctx_t                     ctx4_r;
  logic signed [cdu_pkg::DAYS_W-1:0] days4_r;
  logic signed [cdu_pkg::HR_W-1:0]   hours_r;
  logic signed [cdu_pkg::HR_W-1:0]   hcand4_r;
  cdu_pkg::unit_t                    hunit4_r;

  // stage 5
  logic signed [cdu_pkg::MN_W-1:0]   mins_nxt;
  cdu_pkg::ctx_t                     ctx5_r;
  logic signed [cdu_pkg::DAYS_W-1:0] days5_r;
  logic signed [cdu_pkg::HR_W-1:0]   hcand5_r;
  cdu_pkg::unit_t                    hunit5_r;
  logic signed [cdu_pkg::MN_W-1:0]   mins_r;

  // stage 6
  logic signed [cdu_pkg::SC_W-1:0]   secs;
  logic signed [cdu_pkg::DIFF_W-1:0] diff_nxt;
  cdu_pkg::unit_t                    unit_nxt;
  logic signed [cdu_pkg::DIFF_W-1:0] diff_r;
  cdu_pkg::unit_t                    unit_r;

  assign rdy6     = !v6_r || dn_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;

  // hours = 24*days + dh; divisibility by 3, 6 and 12 depends on dh alone
  assign days4 = up_data.days;
  assign dh4   = up_data.ctx.dh;
  assign neg4  = dh4[cdu_pkg::DH_W-1];
  assign adh   = neg4 ? cdu_pkg::HOUR_W'(-dh4) : cdu_pkg::HOUR_W'(dh4);
  assign q3p   = cdu_pkg::QP_W'(adh) * cdu_pkg::DIV3_K;
  assign q3    = q3p[cdu_pkg::QP_W-1:cdu_pkg::DIV3_SH];
  assign d3    = (adh == ({1'b0, q3} + {q3, 1'b0}));
  assign d6    = d3 && !adh[0];
  assign d12   = d3 && (adh[1:0] == 2'b00);

  assign hours_nxt = (cdu_pkg::HR_W'(days4) <<< 4) + (cdu_pkg::HR_W'(days4) <<< 3)
                   + cdu_pkg::HR_W'(dh4);

  always_comb begin
    if (d12) begin
      hbase     = cdu_pkg::HR_W'(days4) <<< 1;
      qsel      = q3 >> 2;
      hunit_nxt = cdu_pkg::UNIT_12H;
    end else if (d6) begin
      hbase     = cdu_pkg::HR_W'(days4) <<< 2;
      qsel      = q3 >> 1;
      hunit_nxt = cdu_pkg::UNIT_6H;
    end else if (d3) begin
      hbase     = cdu_pkg::HR_W'(days4) <<< 3;
      qsel      = q3;
      hunit_nxt = cdu_pkg::UNIT_3H;
    end else begin
      hbase     = hours_nxt;
      qsel      = '0;
      hunit_nxt = cdu_pkg::UNIT_HOUR;
    end
    qx        = $signed(cdu_pkg::HR_W'(qsel));
    hcand_nxt = hbase + (neg4 ? -qx : qx);
  end

  assign mins_nxt = (cdu_pkg::MN_W'(hours_r) <<< 6) - (cdu_pkg::MN_W'(hours_r) <<< 2)
                  + cdu_pkg::MN_W'(ctx4_r.dmi);

  assign secs = (cdu_pkg::SC_W'(mins_r) <<< 6) - (cdu_pkg::SC_W'(mins_r) <<< 2)
              + cdu_pkg::SC_W'(ctx5_r.ds);

  // coarsest unit first
  always_comb begin
    if (ctx5_r.eq_m && ctx5_r.eq_d && ctx5_r.eq_h && ctx5_r.eq_n && ctx5_r.eq_s) begin
      diff_nxt = cdu_pkg::DIFF_W'(ctx5_r.ydiff);
      unit_nxt = cdu_pkg::UNIT_YEAR;
    end else if (ctx5_r.eq_d && ctx5_r.eq_h && ctx5_r.eq_n && ctx5_r.eq_s) begin
      diff_nxt = cdu_pkg::DIFF_W'(ctx5_r.mdiff);
      unit_nxt = cdu_pkg::UNIT_MONTH;
    end else if (ctx5_r.eq_h && ctx5_r.eq_n && ctx5_r.eq_s) begin
      diff_nxt = cdu_pkg::DIFF_W'(days5_r);
      unit_nxt = cdu_pkg::UNIT_DAY;
    end else if (ctx5_r.eq_n && ctx5_r.eq_s) begin
      diff_nxt = cdu_pkg::DIFF_W'(hcand5_r);
      unit_nxt = hunit5_r;
    end else if (ctx5_r.eq_s) begin
      diff_nxt = cdu_pkg::DIFF_W'(mins_r);
      unit_nxt = cdu_pkg::UNIT_MINUTE;
    end else begin
      diff_nxt = cdu_pkg::DIFF_W'(secs);
      unit_nxt = cdu_pkg::UNIT_SECOND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= up_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ctx4_r   <= up_data.ctx;
      days4_r  <= days4;
      hours_r  <= hours_nxt;
      hcand4_r <= hcand_nxt;
      hunit4_r <= hunit_nxt;
    end
    if (rdy5) begin
      ctx5_r   <= ctx4_r;
      days5_r  <= days4_r;
      hcand5_r <= hcand4_r;
      hunit5_r <= hunit4_r;
      mins_r   <= mins_nxt;
    end
    if (rdy6) begin
      diff_r <= diff_nxt;
      unit_r <= unit_nxt;
    end
  end

  assign dn_valid = v6_r;
  assign dn_diff  = diff_r;
  assign dn_unit  = unit_r;

endmodule

// ----- rtl/calendar_time_difference_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_time_difference_unit
// Six-stage pipeline: one prep stage, two day-number stages and three scale stages.
// Throughput is one request per cycle while not stalled; each stage holds only
// while it is full and the stage after it is held, so a stalled output fills
// bubbles first. Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module calendar_time_difference_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cdu_pkg::YEAR_W-1:0]          in_year_a,
  input  logic [cdu_pkg::MONTH_W-1:0]         in_month_a,
  input  logic [cdu_pkg::DAY_W-1:0]           in_day_a,
  input  logic [cdu_pkg::HOUR_W-1:0]          in_hour_a,
  input  logic [cdu_pkg::MINUTE_W-1:0]        in_minute_a,
  input  logic [cdu_pkg::SECOND_W-1:0]        in_second_a,
  input  logic [cdu_pkg::YEAR_W-1:0]          in_year_b,
  input  logic [cdu_pkg::MONTH_W-1:0]         in_month_b,
  input  logic [cdu_pkg::DAY_W-1:0]           in_day_b,
  input  logic [cdu_pkg::HOUR_W-1:0]          in_hour_b,
  input  logic [cdu_pkg::MINUTE_W-1:0]        in_minute_b,
  input  logic [cdu_pkg::SECOND_W-1:0]        in_second_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cdu_pkg::DIFF_W-1:0]   out_difference,
  output logic [cdu_pkg::UNIT_W-1:0]          out_unit_code
);

  cdu_pkg::stamp_t stamp_a;
  cdu_pkg::stamp_t stamp_b;
  logic            prep_ready;
  logic            prep_valid;
  cdu_pkg::prep_t  prep_data;
  logic            dnum_ready;
  logic            dnum_valid;
  cdu_pkg::days_t  dnum_data;
  logic            scale_ready;
  cdu_pkg::unit_t  unit;

  assign stamp_a = {in_year_a, in_month_a, in_day_a, in_hour_a, in_minute_a, in_second_a};
  assign stamp_b = {in_year_b, in_month_b, in_day_b, in_hour_b, in_minute_b, in_second_b};

  assign in_stall = !prep_ready;

  cdu_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .stamp_a  (stamp_a),
    .stamp_b  (stamp_b),
    .dn_valid (prep_valid),
    .dn_ready (dnum_ready),
    .dn_data  (prep_data)
  );

  cdu_daynum u_daynum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (dnum_ready),
    .up_data  (prep_data),
    .dn_valid (dnum_valid),
    .dn_ready (scale_ready),
    .dn_data  (dnum_data)
  );

  cdu_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dnum_valid),
    .up_ready (scale_ready),
    .up_data  (dnum_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_diff  (out_difference),
    .dn_unit  (unit)
  );

  assign out_unit_code = unit;

endmodule

// ----- test/calendar_time_difference_unit_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_time_difference_unit_tb
// Drives pairs of date-times into the difference pipeline and checks each
// result against a behavioural predictor. It covers unit selection, leap years,
// year saturation and raw out-of-range fields. Both sides idle at random, and
// the receiver holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module calendar_time_difference_unit_tb;

  class diff_scoreboard;
    typedef struct {
      logic signed [cdu_pkg::DIFF_W-1:0] diff;
      logic [cdu_pkg::UNIT_W-1:0]        unit;
    } expected_t;

    expected_t pending_diffs[$];
    int        errors = 0;
    int        month_start[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    function longint clamp_year(logic [cdu_pkg::YEAR_W-1:0] y);
      return (y > cdu_pkg::MAX_YEAR) ? longint'(cdu_pkg::MAX_YEAR) : longint'(y);
    endfunction

    // day number with 1 January of year 0 as day 1; month saturated for the table lookup and leap test
    function longint day_index(longint y, logic [cdu_pkg::MONTH_W-1:0] m,
                               logic [cdu_pkg::DAY_W-1:0] d);
      int     mi;
      longint n;
      mi = (m < 1) ? 1 : ((m > 12) ? 12 : int'(m));
      n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
          + longint'(month_start[mi-1]) + longint'(d);
      if ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)) && mi > 2)
        n++;
      return n;
    endfunction

    function void note_request(cdu_pkg::stamp_t a, cdu_pkg::stamp_t b);
      longint         ya, yb, days, hours, mins, diff;
      cdu_pkg::unit_t unit;
      bit             same_s, same_n, same_h, same_d, same_m;
      expected_t      e;
      ya = clamp_year(a.year);
      yb = clamp_year(b.year);
      same_s = (a.second == b.second);
      same_n = same_s && (a.minute == b.minute);
      same_h = same_n && (a.hour == b.hour);
      same_d = same_h && (a.day == b.day);
      same_m = same_d && (a.month == b.month);
      if (same_m) begin
        diff = ya - yb;
        unit = cdu_pkg::UNIT_YEAR;
      end else if (same_d) begin
        diff = (ya - yb) * 12 + longint'(a.month) - longint'(b.month);
        unit = cdu_pkg::UNIT_MONTH;
      end else begin
        days = day_index(ya, a.month, a.day) - day_index(yb, b.month, b.day);
        hours = days * 24 + longint'(a.hour) - longint'(b.hour);
        mins = hours * 60 + longint'(a.minute) - longint'(b.minute);
        if (same_h) begin
          diff = days;
          unit = cdu_pkg::UNIT_DAY;
        end else if (same_n) begin
          if (hours % 12 == 0) begin
            diff = hours / 12;
            unit = cdu_pkg::UNIT_12H;
          end else if (hours % 6 == 0) begin
            diff = hours / 6;
            unit = cdu_pkg::UNIT_6H;
          end else if (hours % 3 == 0) begin
            diff = hours / 3;
            unit = cdu_pkg::UNIT_3H;
          end else begin
            diff = hours;
            unit = cdu_pkg::UNIT_HOUR;
          end
        end else if (same_s) begin
          diff = mins;
          unit = cdu_pkg::UNIT_MINUTE;
        end else begin
          diff = mins * 60 + longint'(a.second) - longint'(b.second);
          unit = cdu_pkg::UNIT_SECOND;
        end
      end
      e.diff = diff[cdu_pkg::DIFF_W-1:0];
      e.unit = unit;
      pending_diffs.push_back(e);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40)
        $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [cdu_pkg::DIFF_W-1:0] diff,
                      logic [cdu_pkg::UNIT_W-1:0] unit);
      expected_t e;
      if (pending_diffs.size() == 0) begin
        report_mismatch($sformatf("result %0d unit %0d with no request outstanding",
                                  diff, unit));
      end else begin
        e = pending_diffs.pop_front();
        if (diff !== e.diff)
          report_mismatch($sformatf("difference %0d, predicted %0d", diff, e.diff));
        if (unit !== e.unit)
          report_mismatch($sformatf("unit_code %0d, predicted %0d", unit, e.unit));
      end
    endtask
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  cdu_pkg::stamp_t                     req_a;
  cdu_pkg::stamp_t                     req_b;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [cdu_pkg::DIFF_W-1:0]   out_difference;
  logic [cdu_pkg::UNIT_W-1:0]          out_unit_code;

  diff_scoreboard sb;
  int             requests_sent;
  int             results_taken;

  calendar_time_difference_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_year_a     (req_a.year),
    .in_month_a    (req_a.month),
    .in_day_a      (req_a.day),
    .in_hour_a     (req_a.hour),
    .in_minute_a   (req_a.minute),
    .in_second_a   (req_a.second),
    .in_year_b     (req_b.year),
    .in_month_b    (req_b.month),
    .in_day_b      (req_b.day),
    .in_hour_b     (req_b.hour),
    .in_minute_b   (req_b.minute),
    .in_second_b   (req_b.second),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_difference(out_difference),
    .out_unit_code (out_unit_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  function automatic cdu_pkg::stamp_t mk(int y, int m, int d, int h, int n, int s);
    cdu_pkg::stamp_t t;
    t.year   = cdu_pkg::YEAR_W'(y);
    t.month  = cdu_pkg::MONTH_W'(m);
    t.day    = cdu_pkg::DAY_W'(d);
    t.hour   = cdu_pkg::HOUR_W'(h);
    t.minute = cdu_pkg::MINUTE_W'(n);
    t.second = cdu_pkg::SECOND_W'(s);
    return t;
  endfunction

  // every hundredth-block in three runs with no idling at all
  function automatic int idle_cycles(int count);
    if ((count / 100) % 3 == 1)
      return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic cdu_pkg::stamp_t raw_stamp();
    return mk($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
              $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  function automatic cdu_pkg::stamp_t valid_stamp();
    int y;
    case ($urandom_range(0, 9))
      0:       y = 0;
      1:       y = 9999;
      2:       y = 400 * $urandom_range(0, 24);
      default: y = $urandom_range(0, 9999);
    endcase
    return mk(y, $urandom_range(1, 12), $urandom_range(1, 28), $urandom_range(0, 23),
              $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // level picks the finest field left to differ; finer fields are copied across
  task automatic random_pair(output cdu_pkg::stamp_t a, output cdu_pkg::stamp_t b);
    bit raw;
    int level;
    raw = ($urandom_range(0, 6) == 0);
    b = raw ? raw_stamp() : valid_stamp();
    a = raw ? raw_stamp() : valid_stamp();
    level = $urandom_range(0, 6);
    if (level == 6) begin
      a = b;
    end else begin
      if (level < 5) a.second = b.second;
      if (level < 4) a.minute = b.minute;
      if (level < 3) a.hour = b.hour;
      if (level < 2) a.day = b.day;
      if (level < 1) a.month = b.month;
      // favour whole 3-hour steps to reach the coarse hour units
      if (level == 3 && !raw && $urandom_range(0, 1))
        a.hour = cdu_pkg::HOUR_W'((b.hour + 3 * $urandom_range(1, 7)) % 24);
    end
  endtask

  task automatic issue_request(cdu_pkg::stamp_t a, cdu_pkg::stamp_t b);
    int gap;
    gap = idle_cycles(requests_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_a    <= a;
    req_b    <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_request(a, b);
    requests_sent++;
  endtask

  task automatic take_result();
    int                                hold;
    logic signed [cdu_pkg::DIFF_W-1:0] diff;
    logic [cdu_pkg::UNIT_W-1:0]        unit;
    hold = idle_cycles(results_taken);
    // hold long enough to back the pipeline up and stall the input side
    if (results_taken == 150 || results_taken == 520)
      hold = 80;
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(negedge clk); while (!out_valid);
    diff = out_difference;
    unit = out_unit_code;
    @(posedge clk);
    sb.check_result(diff, unit);
    results_taken++;
  endtask

  initial begin
    wait (rst_n === 1'b1);
    forever take_result();
  end

  initial begin
    cdu_pkg::stamp_t a;
    cdu_pkg::stamp_t b;
    sb = new();
    requests_sent = 0;
    results_taken = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    out_stall <= 1'b0;
    req_a     <= '0;
    req_b     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // identical times, year extremes and year saturation
    issue_request(mk(2024, 6, 15, 12, 30, 30), mk(2024, 6, 15, 12, 30, 30));
    issue_request(mk(9999, 12, 31, 23, 59, 59), mk(0, 12, 31, 23, 59, 59));
    issue_request(mk(16383, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0));
    issue_request(mk(16383, 5, 5, 5, 5, 5), mk(9999, 5, 5, 5, 5, 5));
    // months, raw months outside the calendar
    issue_request(mk(2023, 11, 15, 8, 0, 0), mk(2024, 3, 15, 8, 0, 0));
    issue_request(mk(0, 15, 1, 0, 0, 0), mk(0, 0, 1, 0, 0, 0));
    issue_request(mk(100, 0, 5, 1, 0, 0), mk(100, 13, 6, 1, 0, 0));
    // leap-year rules: divisible by 400, by 100 only, and year zero
    issue_request(mk(2000, 3, 1, 0, 0, 0), mk(2000, 2, 28, 0, 0, 0));
    issue_request(mk(1900, 3, 1, 0, 0, 0), mk(1900, 2, 28, 0, 0, 0));
    issue_request(mk(0, 3, 1, 0, 0, 0), mk(0, 2, 28, 0, 0, 0));
    // hour units in both signs
    issue_request(mk(2024, 1, 1, 12, 0, 0), mk(2024, 1, 1, 0, 0, 0));
    issue_request(mk(2024, 1, 1, 6, 0, 0), mk(2024, 1, 1, 0, 0, 0));
    issue_request(mk(2024, 1, 1, 9, 0, 0), mk(2024, 1, 1, 0, 0, 0));
    issue_request(mk(2024, 1, 1, 7, 0, 0), mk(2024, 1, 1, 2, 0, 0));
    issue_request(mk(2024, 1, 1, 0, 0, 0), mk(2024, 1, 2, 12, 0, 0));
    issue_request(mk(2024, 3, 1, 18, 0, 0), mk(2024, 3, 2, 0, 0, 0));
    issue_request(mk(2024, 1, 1, 0, 0, 0), mk(2024, 1, 1, 3, 0, 0));
    // minutes and seconds
    issue_request(mk(2024, 1, 1, 0, 30, 0), mk(2024, 1, 1, 0, 0, 0));
    issue_request(mk(2024, 1, 1, 0, 0, 0), mk(2024, 1, 1, 0, 0, 1));
    // full span both ways
    issue_request(mk(9999, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0));
    issue_request(mk(0, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59));
    // raw fields beyond their ranges, all bits set against all clear
    issue_request(mk(2023, 2, 31, 31, 63, 63), mk(2023, 2, 0, 0, 0, 0));
    issue_request(mk(16383, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0));
    issue_request(mk(0, 0, 0, 0, 0, 0), mk(16383, 15, 31, 31, 63, 63));

    for (int k = 0; k < 800; k++) begin
      random_pair(a, b);
      issue_request(a, b);
    end
    in_valid <= 1'b0;

    while (sb.pending_diffs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_diffs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- calendar_time_difference_unit.f -----
rtl/cdu_pkg.sv
rtl/cdu_prep.sv
rtl/cdu_daynum.sv
rtl/cdu_scale.sv
rtl/calendar_time_difference_unit.sv
test/calendar_time_difference_unit_tb.sv
